// ===== hw/rtl/lseg_pkg.sv =====
// ----------------------------------------------------------------------------
// lseg_pkg
// Shared types, constants and color helpers for the LED strip effect generator.
// ----------------------------------------------------------------------------
package lseg_pkg;

	localparam int unsigned MAX_LEDS_DEFAULT = 256;

	localparam int unsigned DIV_STEPS   = 16;  // dividend is pixel_index * 256
	localparam int unsigned BLEND_STEPS = 8;   // one luminance bit per cycle
	localparam int unsigned CNT_W       = $clog2(DIV_STEPS);

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_PRIMARY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_SECONDARY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED           = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_LEDS        = 3'd4;

	localparam logic [15:0] SPEED_RESET     = 16'd1000;
	localparam logic [8:0]  NUM_LEDS_RESET  = 9'd1;
	localparam logic [9:0]  STATIC_DELAY    = 10'd1000;
	localparam logic [9:0]  BREATH_STEP_MAX = 10'd497;  // 512 - 15
	localparam logic [8:0]  BREATH_RESTART  = 9'd15;
	localparam logic [7:0]  WHEEL_THIRD     = 8'd85;
	localparam logic [7:0]  WHEEL_TWO_THIRD = 8'd170;

	typedef enum logic [1:0] {
		MODE_SOLID = 2'd0,
		MODE_FILL  = 2'd1,
		MODE_CYCLE = 2'd2,
		MODE_PULSE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	// control group for the serial units
	typedef struct packed {
		logic start;
		logic step;
	} ctl_t;

	function automatic logic [31:0] wheel(input logic [7:0] p);
		logic [7:0] q;
		logic [7:0] q3;
		logic [31:0] c;
		q = ~p;
		if (q < WHEEL_THIRD) begin
			q3 = 8'(10'(q) * 10'd3);
			c = {8'h00, 8'hFF - q3, 8'h00, q3};
		end else if (q < WHEEL_TWO_THIRD) begin
			q3 = 8'(10'(q - WHEEL_THIRD) * 10'd3);
			c = {8'h00, 8'h00, q3, 8'hFF - q3};
		end else begin
			q3 = 8'(10'(q - WHEEL_TWO_THIRD) * 10'd3);
			c = {8'h00, q3, 8'hFF - q3, 8'h00};
		end
		return c;
	endfunction

	function automatic logic [9:0] breath_delay(input logic [7:0] lum);
		logic [9:0] d;
		if (lum == 8'd15)       d = 10'd970;
		else if (lum <= 8'd25)  d = 10'd38;
		else if (lum <= 8'd50)  d = 10'd36;
		else if (lum <= 8'd75)  d = 10'd28;
		else if (lum <= 8'd100) d = 10'd20;
		else if (lum <= 8'd125) d = 10'd14;
		else if (lum <= 8'd150) d = 10'd11;
		else                    d = 10'd10;
		return d;
	endfunction

endpackage

// ===== hw/rtl/lseg_div.sv =====
// ----------------------------------------------------------------------------
// lseg_div
// Restoring divider, one quotient bit per cycle (pixel_index * 256 / LED count).
// ----------------------------------------------------------------------------
module lseg_div (
	input  logic            clk,
	input  lseg_pkg::ctl_t  ctl,
	input  logic [15:0]     dividend,
	input  logic [8:0]      divisor,
	output logic [7:0]      quotient
);

	logic [15:0] dq_q;   // dividend bits shift out the top, quotient bits in the bottom
	logic [8:0]  rem_q;
	logic [8:0]  div_q;
	logic [9:0]  trial;
	logic        ge;

	assign trial = {rem_q, dq_q[15]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (ctl.step) begin
			// remainder stays below the divisor, so 9 bits hold it
			rem_q <= ge ? 9'(trial - {1'b0, div_q}) : trial[8:0];
			dq_q  <= {dq_q[14:0], ge};
		end
	end

	// only the low byte is used after the mod-256 wrap
	assign quotient = dq_q[7:0];

endmodule

// ===== hw/rtl/lseg_blend.sv =====
// ----------------------------------------------------------------------------
// lseg_blend
// Four-lane bit-serial blend: (to * amt + from * (255 - amt)) / 256 per byte; amt 0 and 255 pass from and to through.
// ----------------------------------------------------------------------------
module lseg_blend (
	input  logic            clk,
	input  lseg_pkg::ctl_t  ctl,
	input  logic [31:0]     from_color,
	input  logic [31:0]     to_color,
	input  logic [7:0]      amt,
	output logic [31:0]     color
);

	logic [7:0]  amt_q;
	logic        zero_q;
	logic        full_q;
	logic [31:0] mixed;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			amt_q  <= amt;
			zero_q <= amt == 8'h00;
			full_q <= amt == 8'hFF;
		end else if (ctl.step) begin
			amt_q <= {amt_q[6:0], 1'b0};
		end
	end

	// 255 - amt is ~amt, so each amt bit picks either the to or the from byte
	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic [7:0]  sel;
		logic [15:0] acc_q;
		assign sel = amt_q[7] ? to_color[8*l +: 8] : from_color[8*l +: 8];

		always_ff @(posedge clk) begin
			if (ctl.start) begin
				acc_q <= '0;
			end else if (ctl.step) begin
				acc_q <= {acc_q[14:0], 1'b0} + {8'h00, sel};
			end
		end

		assign mixed[8*l +: 8] = acc_q[15:8];
	end

	always_comb begin
		if (zero_q)      color = from_color;
		else if (full_q) color = to_color;
		else             color = mixed;
	end

endmodule

// ===== hw/rtl/led_strip_effect_generator.sv =====
// ----------------------------------------------------------------------------
// led_strip_effect_generator
// Sequence: an input transaction starts the 16 serial steps of the divider,
// which also cover the 8-step blend, then ST_HOLD loads the output register.
// One item in flight: a new input is taken only in ST_IDLE, and
// a result left waiting holds the block in its final state.
// Reset: arst_n clears control state, step counter and config to defaults.
// ----------------------------------------------------------------------------
module led_strip_effect_generator #(
	parameter int unsigned MAX_LEDS = lseg_pkg::MAX_LEDS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_we,
	input  logic [lseg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lseg_pkg::CFG_DATA_W-1:0] cfg_data,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      pixel_index,
	input  logic                            frame_end,

	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [31:0]                     pixel_color,
	output logic [9:0]                      frame_delay,
	output logic                            cycle_done
);

	// configuration
	lseg_pkg::mode_t effect_mode_q;
	logic [31:0]     color_primary_q;
	logic [31:0]     color_secondary_q;
	logic [15:0]     speed_q;
	logic [8:0]      num_leds_q;

	logic [8:0]      step_q;

	lseg_pkg::state_t             state_q, state_d;
	logic [lseg_pkg::CNT_W-1:0]   cnt_q;

	logic [7:0]  step_old_q;
	logic [9:0]  delay_q;
	logic        done_q;

	logic        out_valid_q;
	logic [31:0] pixel_color_q;
	logic [9:0]  frame_delay_q;
	logic        cycle_done_q;

	logic        accept;
	logic        out_free;
	logic        load_out;
	logic        last_step;

	lseg_pkg::ctl_t div_ctl;
	lseg_pkg::ctl_t blend_ctl;

	logic [8:0]  n_eff;
	logic [7:0]  lum;
	logic [8:0]  step_d;
	logic [9:0]  delay_d;
	logic        done_d;
	logic [9:0]  breath_next;

	logic [7:0]  quotient;
	logic [31:0] blend_color;
	logic [31:0] color_d;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign last_step = cnt_q == lseg_pkg::CNT_W'(lseg_pkg::DIV_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_mode_q     <= lseg_pkg::MODE_SOLID;
			color_primary_q   <= '0;
			color_secondary_q <= '0;
			speed_q           <= lseg_pkg::SPEED_RESET;
			num_leds_q        <= lseg_pkg::NUM_LEDS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lseg_pkg::REG_EFFECT_MODE:     effect_mode_q     <= lseg_pkg::mode_t'(cfg_data[1:0]);
				lseg_pkg::REG_COLOR_PRIMARY:   color_primary_q   <= cfg_data;
				lseg_pkg::REG_COLOR_SECONDARY: color_secondary_q <= cfg_data;
				lseg_pkg::REG_SPEED:           speed_q           <= cfg_data[15:0];
				lseg_pkg::REG_NUM_LEDS:        num_leds_q        <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// zero LEDs counts as one; saturate at MAX_LEDS
	always_comb begin
		if (num_leds_q == '0)
			n_eff = 9'd1;
		else if (32'(num_leds_q) > 32'(MAX_LEDS))
			n_eff = 9'(MAX_LEDS);
		else
			n_eff = num_leds_q;
	end

	// breath folds the step: 511 - step above 255
	assign lum = step_q[8] ? ~step_q[7:0] : step_q[7:0];
	assign breath_next = {1'b0, step_q} + 10'd2;

	always_comb begin
		step_d  = step_q;
		delay_d = '0;
		done_d  = 1'b0;
		case (effect_mode_q)
			lseg_pkg::MODE_SOLID: begin
				delay_d = lseg_pkg::STATIC_DELAY;
				done_d  = frame_end;
			end
			lseg_pkg::MODE_FILL, lseg_pkg::MODE_CYCLE: begin
				delay_d = {2'b00, speed_q[15:8]};
				if (frame_end) begin
					step_d = {1'b0, 8'(step_q[7:0] + 8'd1)};
					done_d = step_q[7:0] == 8'hFF;
				end
			end
			default: begin
				delay_d = lseg_pkg::breath_delay(lum);
				if (frame_end) begin
					if (breath_next > lseg_pkg::BREATH_STEP_MAX) begin
						step_d = lseg_pkg::BREATH_RESTART;
						done_d = 1'b1;
					end else begin
						step_d = breath_next[8:0];
					end
				end
			end
		endcase
		if (!frame_end)
			delay_d = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= '0;
		else if (accept)
			step_q <= step_d;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_old_q <= step_q[7:0];
			delay_q    <= delay_d;
			done_q     <= done_d;
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			lseg_pkg::ST_IDLE: if (accept)    state_d = lseg_pkg::ST_RUN;
			lseg_pkg::ST_RUN:  if (last_step) state_d = lseg_pkg::ST_HOLD;
			lseg_pkg::ST_HOLD: if (out_free)  state_d = lseg_pkg::ST_IDLE;
			default:                          state_d = lseg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = state_q == lseg_pkg::ST_IDLE;
		load_out        = state_q == lseg_pkg::ST_HOLD && out_free;
		div_ctl.start   = accept;
		div_ctl.step    = state_q == lseg_pkg::ST_RUN;
		blend_ctl.start = accept;
		blend_ctl.step  = state_q == lseg_pkg::ST_RUN &&
			cnt_q < lseg_pkg::CNT_W'(lseg_pkg::BLEND_STEPS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lseg_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept)
				cnt_q <= '0;
			else if (state_q == lseg_pkg::ST_RUN)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	lseg_div u_div (
		.clk      (clk),
		.ctl      (div_ctl),
		.dividend ({pixel_index, 8'h00}),
		.divisor  (n_eff),
		.quotient (quotient)
	);

	lseg_blend u_blend (
		.clk        (clk),
		.ctl        (blend_ctl),
		.from_color (color_secondary_q),
		.to_color   (color_primary_q),
		.amt        (lum),
		.color      (blend_color)
	);

	always_comb begin
		case (effect_mode_q)
			lseg_pkg::MODE_SOLID: color_d = color_primary_q;
			lseg_pkg::MODE_FILL:  color_d = lseg_pkg::wheel(step_old_q);
			lseg_pkg::MODE_CYCLE: color_d = lseg_pkg::wheel(quotient + step_old_q);
			default:              color_d = blend_color;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pixel_color_q <= color_d;
			frame_delay_q <= delay_q;
			cycle_done_q  <= done_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_color = pixel_color_q;
	assign frame_delay = frame_delay_q;
	assign cycle_done  = cycle_done_q;

endmodule

// ===== hw/rtl/lseg_checker.sv =====
// ----------------------------------------------------------------------------
// lseg_checker
// Port-level checks for the LED strip effect generator, bound to the top level.
// ----------------------------------------------------------------------------
module lseg_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_we,
	input logic [lseg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [lseg_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [7:0]                      pixel_index,
	input logic                            frame_end,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [31:0]                     pixel_color,
	input logic [9:0]                      frame_delay,
	input logic                            cycle_done
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_color) &&
		$stable(frame_delay) && $stable(cycle_done))
		else $error("result changed while stalled");

	// one item in flight: ready drops after a transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// an idle block stays idle without a transaction
	a_idle_stays: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("ready dropped without a transaction");

	// a new result comes only from a busy block
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work");

endmodule

bind led_strip_effect_generator lseg_checker u_lseg_checker (.*);
